// ===== rtl/cgs_pkg.sv =====
package cgs_pkg;

  localparam int GRID_DIM   = 256;
  localparam int MAX_RADIUS = 15;
  localparam int IW = $clog2(GRID_DIM);
  localparam int AW = 2 * IW;
  localparam int CW = $clog2(GRID_DIM + MAX_RADIUS) + 1;
  localparam int RW = (MAX_RADIUS > 1) ? $clog2(MAX_RADIUS + 1) : 1;

  localparam logic [1:0] FN_POS   = 2'd0;
  localparam logic [1:0] FN_CELL  = 2'd1;
  localparam logic [1:0] FN_MASK  = 2'd2;
  localparam logic [1:0] FN_CLEAR = 2'd3;

  localparam logic [2:0] REG_ORIGIN_LAT   = 3'd0;
  localparam logic [2:0] REG_ORIGIN_LON   = 3'd1;
  localparam logic [2:0] REG_LON_SCALE    = 3'd2;
  localparam logic [2:0] REG_LAT_SCALE    = 3'd3;
  localparam logic [2:0] REG_GRID_WIDTH   = 3'd4;
  localparam logic [2:0] REG_GRID_HEIGHT  = 3'd5;
  localparam logic [2:0] REG_STAMP_RADIUS = 3'd6;
  localparam logic [2:0] REG_MASK_ENABLE  = 3'd7;

  typedef enum logic [3:0] {
    ST_INIT, ST_IDLE, ST_LOCATE, ST_STAMP, ST_DRAIN,
    ST_MASK_RD, ST_MASK_WR, ST_WIPE, ST_DONE
  } state_t;

  typedef struct packed {
    logic          done;
    logic          ok;
    logic [IW-1:0] x;
    logic [IW-1:0] y;
  } loc_res_t;

endpackage

// ===== rtl/cgs_ram.sv =====
module cgs_ram #(
  parameter int DEPTH = 65536,
  parameter int AWID  = $clog2(DEPTH)
) (
  input  logic            clk,
  input  logic            we,
  input  logic [AWID-1:0] waddr,
  input  logic            wdata,
  input  logic [AWID-1:0] raddr,
  output logic            rdata
);

  logic mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/cgs_locate.sv =====
module cgs_locate (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic signed [30:0]    lat,
  input  logic signed [31:0]    lon,
  input  logic signed [30:0]    origin_lat,
  input  logic signed [31:0]    origin_lon,
  input  logic [31:0]           lon_scale,
  input  logic [31:0]           lat_scale,
  input  logic [8:0]            w_eff,
  input  logic [8:0]            h_eff,
  output cgs_pkg::loc_res_t     res
);
  import cgs_pkg::*;

  logic [1:0]  step_r;
  logic [31:0] magx_r, magy_r;
  logic        negx_r, negy_r;
  logic [63:0] prod_r;
  logic        okx_r;
  logic [IW-1:0] px_r;

  logic signed [32:0] dx, dy;
  logic [32:0] adx, ady;
  logic [31:0] qx, qy;
  logic        okx, oky;

  always_comb begin
    dx  = {lon[31], lon} - {origin_lon[31], origin_lon};
    dy  = {{2{origin_lat[30]}}, origin_lat} - {{2{lat[30]}}, lat};
    adx = dx[32] ? (33'd0 - dx) : dx;
    ady = dy[32] ? (33'd0 - dy) : dy;
    // A negative offset lands in cell zero only when the scale is zero.
    qx  = negx_r ? 32'd0 : prod_r[63:32];
    okx = (negx_r ? (prod_r == 64'd0) : 1'b1) && (qx < {23'd0, w_eff});
    qy  = negy_r ? 32'd0 : prod_r[63:32];
    oky = (negy_r ? (prod_r == 64'd0) : 1'b1) && (qy < {23'd0, h_eff});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= 2'd0;
    end else begin
      unique case (step_r)
        2'd0: if (start) step_r <= 2'd1;
        default: step_r <= step_r + 2'd1;
      endcase
    end
    if (start) begin
      magx_r <= adx[31:0];
      negx_r <= dx[32];
      magy_r <= ady[31:0];
      negy_r <= dy[32];
    end
    if (step_r == 2'd1) prod_r <= magx_r * lon_scale;
    if (step_r == 2'd2) begin
      prod_r <= magy_r * lat_scale;
      okx_r  <= okx;
      px_r   <= qx[IW-1:0];
    end
  end

  always_comb begin
    res.done = (step_r == 2'd3);
    res.ok   = okx_r && oky;
    res.x    = px_r;
    res.y    = qy[IW-1:0];
  end

endmodule

// ===== rtl/coverage_grid_stamp.sv =====
// Channel  Direction  Payload
// in_      slave      tuser: func; tdata: lat, lon, cell_x, cell_y, mask_bit
// out_     master     tdata: covered_count, area_count, newly_covered, in_grid
// cfg_     slave      cfg_index selects the register, cfg_data carries its value
//
// After reset the block sweeps both bitmaps, clearing every cell, before it takes an item.
// A position item first locates its center, then stamps the cells of the square
// (up to 961) one per cycle; a cell item stamps one cell, a mask load reads then writes.
// Clearing coverage sweeps every cell of the covered bitmap.
// The rate is set by the single read-modify-write port pair of the bitmaps.
// A finished result waits in the output register while the next item is taken.
module coverage_grid_stamp (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [79:0] in_tdata,   // lat, lon, cell_x, cell_y, mask_bit
  input  logic [1:0]  in_tuser,   // func
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // covered_count, area_count, newly_covered, in_grid, pad
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import cgs_pkg::*;

  logic signed [30:0] origin_lat_r;
  logic signed [31:0] origin_lon_r;
  logic [31:0] lon_scale_r, lat_scale_r;
  logic [8:0]  grid_width_r, grid_height_r;
  logic [3:0]  stamp_radius_r;
  logic        mask_enable_r;

  state_t state_r, state_nxt;
  logic [AW-1:0] sweep_r;
  logic signed [CW-1:0] ix_r, iy_r, cx_r, cy_r;
  logic [RW-1:0] rad_r;
  logic        mbit_r;
  logic        p_valid_r;
  logic [AW-1:0] p_addr_r;
  logic [9:0]  newly_r;
  logic        inside_r;
  logic [16:0] covered_total_r, mask_total_r;
  logic        out_valid_r;
  logic [47:0] out_data_r;

  logic        acc;
  logic [1:0]  in_func;
  logic signed [30:0] in_lat;
  logic signed [31:0] in_lon;
  logic [7:0]  in_cx, in_cy;
  logic        in_mbit, in_cell_ok;
  logic [8:0]  w_eff, h_eff;
  logic [RW-1:0] r_eff;
  logic signed [CW-1:0] wc, hc, rc, lx, ly;
  logic        cell_in, last_cell, out_free, sweep_end, do_mark;
  logic [AW-1:0] cur_addr;
  logic        cov_we, cov_wd, cov_q, msk_we, msk_wd, msk_q;
  logic [AW-1:0] cov_wa, msk_wa;
  logic [17:0] wh;
  logic [16:0] area;
  loc_res_t    loc;

  assign in_func = in_tuser;
  assign in_lat  = in_tdata[30:0];
  assign in_lon  = in_tdata[62:31];
  assign in_cx   = in_tdata[70:63];
  assign in_cy   = in_tdata[78:71];
  assign in_mbit = in_tdata[79];

  assign cfg_ready = 1'b1;
  assign acc       = in_tvalid && in_tready;

  always_comb begin
    w_eff = (grid_width_r > 9'(GRID_DIM)) ? 9'(GRID_DIM) : grid_width_r;
    h_eff = (grid_height_r > 9'(GRID_DIM)) ? 9'(GRID_DIM) : grid_height_r;
    r_eff = (stamp_radius_r > 4'(MAX_RADIUS)) ? RW'(MAX_RADIUS) : RW'(stamp_radius_r);
    wc = CW'(w_eff);
    hc = CW'(h_eff);
    rc = CW'(rad_r);
    lx = cx_r + rc;
    ly = cy_r + rc;
    in_cell_ok = ({1'b0, in_cx} < w_eff) && ({1'b0, in_cy} < h_eff);
    cell_in    = !ix_r[CW-1] && !iy_r[CW-1] && (ix_r < wc) && (iy_r < hc);
    last_cell  = (ix_r == lx) && (iy_r == ly);
    cur_addr   = {iy_r[IW-1:0], ix_r[IW-1:0]};
    out_free   = !out_valid_r || out_tready;
    sweep_end  = (sweep_r == {AW{1'b1}});
    do_mark    = p_valid_r && (!mask_enable_r || msk_q) && !cov_q;
    wh   = w_eff * h_eff;
    area = mask_enable_r ? mask_total_r : wh[16:0];
  end

  cgs_locate u_locate (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (acc && (in_func == FN_POS)),
    .lat        (in_lat),
    .lon        (in_lon),
    .origin_lat (origin_lat_r),
    .origin_lon (origin_lon_r),
    .lon_scale  (lon_scale_r),
    .lat_scale  (lat_scale_r),
    .w_eff      (w_eff),
    .h_eff      (h_eff),
    .res        (loc)
  );

  cgs_ram #(.DEPTH(GRID_DIM * GRID_DIM)) u_cov_ram (
    .clk   (clk),
    .we    (cov_we),
    .waddr (cov_wa),
    .wdata (cov_wd),
    .raddr (cur_addr),
    .rdata (cov_q)
  );

  cgs_ram #(.DEPTH(GRID_DIM * GRID_DIM)) u_msk_ram (
    .clk   (clk),
    .we    (msk_we),
    .waddr (msk_wa),
    .wdata (msk_wd),
    .raddr (cur_addr),
    .rdata (msk_q)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_INIT:    if (sweep_end) state_nxt = ST_IDLE;
      ST_IDLE: begin
        if (acc) begin
          unique case (in_func)
            FN_POS:   state_nxt = ST_LOCATE;
            FN_CELL:  state_nxt = in_cell_ok ? ST_STAMP : ST_DONE;
            FN_MASK:  state_nxt = in_cell_ok ? ST_MASK_RD : ST_DONE;
            default:  state_nxt = ST_WIPE;
          endcase
        end
      end
      ST_LOCATE:  if (loc.done) state_nxt = loc.ok ? ST_STAMP : ST_DONE;
      ST_STAMP:   if (last_cell) state_nxt = ST_DRAIN;
      ST_DRAIN:   state_nxt = ST_DONE;
      ST_MASK_RD: state_nxt = ST_MASK_WR;
      ST_MASK_WR: state_nxt = ST_DONE;
      ST_WIPE:    if (sweep_end) state_nxt = ST_DONE;
      ST_DONE:    if (out_free) state_nxt = ST_IDLE;
      default:    state_nxt = ST_INIT;
    endcase
  end

  // Memory controls and handshake outputs.
  always_comb begin
    in_tready = (state_r == ST_IDLE);
    cov_we = 1'b0;
    cov_wa = p_addr_r;
    cov_wd = 1'b1;
    msk_we = 1'b0;
    msk_wa = cur_addr;
    msk_wd = mbit_r;
    unique case (state_r)
      ST_INIT: begin
        cov_we = 1'b1;
        cov_wa = sweep_r;
        cov_wd = 1'b0;
        msk_we = 1'b1;
        msk_wa = sweep_r;
        msk_wd = 1'b0;
      end
      ST_WIPE: begin
        cov_we = 1'b1;
        cov_wa = sweep_r;
        cov_wd = 1'b0;
      end
      ST_MASK_WR: msk_we = 1'b1;
      default:    cov_we = do_mark;
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= ST_INIT;
      sweep_r         <= '0;
      p_valid_r       <= 1'b0;
      out_valid_r     <= 1'b0;
      covered_total_r <= '0;
      mask_total_r    <= '0;
      origin_lat_r    <= '0;
      origin_lon_r    <= '0;
      lon_scale_r     <= '0;
      lat_scale_r     <= '0;
      grid_width_r    <= '0;
      grid_height_r   <= '0;
      stamp_radius_r  <= 4'd1;
      mask_enable_r   <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      p_valid_r <= (state_r == ST_STAMP) && cell_in;
      if ((state_r == ST_INIT) || (state_r == ST_WIPE)) sweep_r <= sweep_r + 1'b1;
      if (state_r == ST_WIPE) covered_total_r <= '0;
      else if (do_mark) covered_total_r <= covered_total_r + 17'd1;
      if (state_r == ST_MASK_WR) begin
        if (mbit_r && !msk_q) mask_total_r <= mask_total_r + 17'd1;
        else if (!mbit_r && msk_q) mask_total_r <= mask_total_r - 17'd1;
      end
      if ((state_r == ST_DONE) && out_free) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_ORIGIN_LAT:   origin_lat_r   <= cfg_data[30:0];
          REG_ORIGIN_LON:   origin_lon_r   <= cfg_data;
          REG_LON_SCALE:    lon_scale_r    <= cfg_data;
          REG_LAT_SCALE:    lat_scale_r    <= cfg_data;
          REG_GRID_WIDTH:   grid_width_r   <= cfg_data[8:0];
          REG_GRID_HEIGHT:  grid_height_r  <= cfg_data[8:0];
          REG_STAMP_RADIUS: stamp_radius_r <= cfg_data[3:0];
          default:          mask_enable_r  <= cfg_data[0];
        endcase
      end
    end

    p_addr_r <= cur_addr;
    if (do_mark) newly_r <= newly_r + 10'd1;
    if (acc) begin
      newly_r  <= '0;
      inside_r <= ((in_func == FN_CELL) || (in_func == FN_MASK)) && in_cell_ok;
      mbit_r   <= in_mbit;
      ix_r     <= CW'(in_cx);
      iy_r     <= CW'(in_cy);
      cx_r     <= CW'(in_cx);
      cy_r     <= CW'(in_cy);
      rad_r    <= '0;
    end
    if ((state_r == ST_LOCATE) && loc.done) begin
      inside_r <= loc.ok;
      rad_r    <= r_eff;
      cx_r     <= CW'(loc.x);
      cy_r     <= CW'(loc.y);
      ix_r     <= CW'(loc.x) - CW'(r_eff);
      iy_r     <= CW'(loc.y) - CW'(r_eff);
    end
    if ((state_r == ST_STAMP) && !last_cell) begin
      if (iy_r == ly) begin
        iy_r <= cy_r - rc;
        ix_r <= ix_r + 1'b1;
      end else begin
        iy_r <= iy_r + 1'b1;
      end
    end
    if ((state_r == ST_DONE) && out_free) begin
      out_data_r <= {3'd0, inside_r, newly_r, area, covered_total_r};
    end
  end

endmodule
